// ===== hw/rtl/boolean_matrix_multiply_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Boolean matrix multiply unit - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef BOOLEAN_MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define BOOLEAN_MATRIX_MULTIPLY_UNIT_MACROS_SVH

// Same-cycle implication.
`define BMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bmm_pkg
// Types, constants and helpers of the boolean matrix multiply unit.
// ----------------------------------------------------------------------------
package bmm_pkg;

  localparam int DIM       = 16;             // rows and columns stored
  localparam int ROW_W     = 16;             // row bit vector
  localparam int IDX_W     = $clog2(DIM);    // row index
  localparam int CNT_W     = 5;              // count registers
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 2'd2;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(DIM);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW,
    S_INNER,
    S_DRAIN
  } state_t;

  // Saturate a count to the stored dimension.
  function automatic logic [CNT_W-1:0] clamp_dim(input logic [CNT_W-1:0] n);
    clamp_dim = (n > CNT_W'(DIM)) ? CNT_W'(DIM) : n;
  endfunction

endpackage

// ===== hw/rtl/bmm_ram.sv =====
// ----------------------------------------------------------------------------
// bmm_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next enabled read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/boolean_matrix_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// boolean_matrix_multiply_unit
// Boolean matrix product C = A*B over stored rows of A and B.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transfer when          Payload
// -------   ---------  ---------------------  ----------------------------------
// request   in         start && !busy         req_type, row_index, row_bits
// result    out        result_strobe          out_row_index, out_row_bits, last_row
// config    in         cfg_we                 cfg_index, cfg_data
//
// A row load never raises busy. A compute request holds busy through its rows
// (one A read, one B read per inner step through the single B read port, one
// drain step per row); each result row appears in the cycle after its drain
// step, for a single cycle. rst is synchronous: the sequencer returns to idle,
// counts go to 16, stored rows stay undefined until loaded. The receiver cannot
// stall results.
//
`include "boolean_matrix_multiply_unit_macros.svh"

module boolean_matrix_multiply_unit (
  input  logic                          clk,
  input  logic                          rst,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic [bmm_pkg::REQ_W-1:0]     req_type,
  input  logic [bmm_pkg::IDX_W-1:0]     row_index,
  input  logic [bmm_pkg::ROW_W-1:0]     row_bits,
  // result
  output logic                          result_strobe,
  output logic [bmm_pkg::IDX_W-1:0]     out_row_index,
  output logic [bmm_pkg::ROW_W-1:0]     out_row_bits,
  output logic                          last_row,
  // configuration
  input  logic                          cfg_we,
  input  logic [bmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmm_pkg::CNT_W-1:0]     cfg_data
);
  import bmm_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] inner_count;
  logic [CNT_W-1:0] col_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= CNT_RESET;
      inner_count <= CNT_RESET;
      col_count   <= CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:   row_count   <= cfg_data;
        CFG_INNER_COUNT: inner_count <= cfg_data;
        CFG_COL_COUNT:   col_count   <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // effective sizes, saturated to the stored dimension
  logic [CNT_W-1:0] rows_eff;
  logic [CNT_W-1:0] inner_eff;
  logic [CNT_W-1:0] col_eff;
  logic [ROW_W-1:0] col_mask;

  assign rows_eff  = clamp_dim(row_count);
  assign inner_eff = clamp_dim(inner_count);
  assign col_eff   = clamp_dim(col_count);

  always_comb begin
    for (int c = 0; c < ROW_W; c++) begin
      col_mask[c] = (CNT_W'(c) < col_eff);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] i_cnt;      // result row
  logic [IDX_W-1:0] k_cnt;      // inner step, B read address
  logic             pend;       // B read data due this cycle
  logic [IDX_W-1:0] pend_k;     // inner step of that read
  logic [ROW_W-1:0] acc;

  logic             accept;
  logic             is_compute;
  logic             k_last;
  logic             i_last;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign is_compute = (req_type == REQ_COMPUTE);
  assign k_last     = ({1'b0, k_cnt} == (inner_eff - CNT_W'(1)));
  assign i_last     = (({1'b0, i_cnt} + CNT_W'(1)) == rows_eff);

  // --------------------------------------------------------------------------
  // Row stores: loads only while idle, reads only while busy, so the
  // busy interlock keeps write and read of one row from overlapping.
  // --------------------------------------------------------------------------
  logic             a_we, b_we;
  logic             a_re, b_re;
  logic [IDX_W-1:0] a_raddr, b_raddr;
  logic [ROW_W-1:0] a_rdata, b_rdata;

  bmm_ram #(.WIDTH(ROW_W), .DEPTH(DIM)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (row_index),
    .wdata (row_bits),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  bmm_ram #(.WIDTH(ROW_W), .DEPTH(DIM)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (row_index),
    .wdata (row_bits),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        // zero row count: request taken, nothing emitted
        if (accept && is_compute && (rows_eff != '0)) begin
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        state_next = (inner_eff == '0) ? S_DRAIN : S_INNER;
      end
      S_INNER: begin
        if (k_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = i_last ? S_IDLE : S_ROW;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] term;
  logic [ROW_W-1:0] acc_next;

  always_comb begin
    a_we    = accept && (req_type == REQ_LOAD_A);
    b_we    = accept && (req_type == REQ_LOAD_B);
    a_re    = (state == S_ROW);
    b_re    = (state == S_INNER);
    a_raddr = i_cnt;
    b_raddr = k_cnt;
    // A row stays in the read register for the whole row; A bits at or past
    // the inner count are never selected
    term     = (pend && a_rdata[pend_k]) ? b_rdata : '0;
    acc_next = acc | term;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pend          <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      pend          <= b_re;
      result_strobe <= (state == S_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    pend_k <= k_cnt;
    unique case (state)
      S_IDLE: begin
        i_cnt <= '0;
      end
      S_ROW: begin
        acc   <= '0;
        k_cnt <= '0;
      end
      S_INNER: begin
        acc   <= acc_next;
        k_cnt <= k_cnt + IDX_W'(1);
      end
      S_DRAIN: begin
        out_row_index <= i_cnt;
        out_row_bits  <= acc_next & col_mask;
        last_row      <= i_last;
        i_cnt         <= i_cnt + IDX_W'(1);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BMM_ASSERT_IMP(a_strobe_after_drain, result_strobe, $past(state) == S_DRAIN, "strobe without drain step")
  `BMM_ASSERT_IMP(a_last_ends_product, result_strobe && last_row, state == S_IDLE, "last row while still busy")
  `BMM_ASSERT_NEXT(a_compute_starts, accept && is_compute && (rows_eff != '0), busy, "compute not started")
  `BMM_ASSERT_IMP(a_pend_in_walk, pend, state == S_INNER || state == S_DRAIN, "B data outside row walk")

endmodule
